// File: hdl/assert_macros.svh
// Assertion macros used by the RTL of the double integrator block.
// Depends on nothing; ASSERT_CLK expects signals clk and rst_n in scope, ASSERT_ALWAYS only clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/dicl_pkg.sv
// Package for the clamped double integrator: default widths, register
// indexes, operation codes and the sequencer state type. Depends on nothing.
`default_nettype none

package dicl_pkg;

    localparam int DEF_WORD_BITS = 32;
    localparam int DEF_FRAC_BITS = 16;

    // Configuration register indexes.
    localparam logic CFG_MAX_ACCEL = 1'b0;
    localparam logic CFG_MAX_VEL   = 1'b1;

    // Input operation codes.
    localparam logic OP_INIT = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_SQL,
        ST_CMP,
        ST_ROOT,
        ST_MULX,
        ST_DIVX,
        ST_MULY,
        ST_DIVY,
        ST_FIN,
        ST_OUT
    } dicl_state_t;

endpackage

`default_nettype wire

// File: hdl/double_integrator_clamped_step.sv
// An initialize beat goes straight to the output register. A step beat runs an acceleration pass and
// then a velocity pass; each squares and compares on the bit-serial multiplier, and when its limit
// bites it also runs the bit-serial square root, multiplier and divider to rescale the vector.
// Throughput: one beat at a time; the next beat can be taken in the cycle after a result is loaded,
// and a finished result waits in its own output register.
// Reset (rst_n, asynchronous, active low) clears the state to zero and both limits to 1.0.
`default_nettype none

`include "assert_macros.svh"

module double_integrator_clamped_step
    import dicl_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // Input beats.
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // tdata, from bit 0: grad_x, grad_y, start_x, start_y, zero padding
    input  wire logic [((4*WORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
    // tuser: operation
    input  wire logic                                   s_axis_tuser,
    // Result beats.
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // tdata, from bit 0: pos_x, pos_y, vel_x, vel_y, zero padding
    output logic [((4*WORD_BITS+7)/8)*8-1:0]            m_axis_tdata,
    // tuser, from bit 0: accel_limited, speed_limited
    output logic [1:0]                                  m_axis_tuser,
    // Configuration writes.
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic                                   cfg_index,
    input  wire logic [WORD_BITS-2:0]                   cfg_data
);

    localparam int W      = WORD_BITS;
    localparam int W2     = 2 * WORD_BITS;
    localparam int CW     = $clog2(2 * WORD_BITS + 2);
    localparam int TD_W   = ((4 * WORD_BITS + 7) / 8) * 8;
    localparam logic [W-2:0] LIM_ONE = {{(W-2){1'b0}}, 1'b1} << FRAC_BITS;
    localparam logic signed [W+2:0] SMAX_E = {4'b0000, {(W-1){1'b1}}};
    localparam logic signed [W+2:0] SMIN_E = {4'b1111, {(W-1){1'b0}}};

    // Sequencer and counter.
    dicl_state_t     state_reg, state_next;
    logic [CW-1:0]   cnt_reg;
    logic            last_mul, last_div;

    // Architectural state and limits.
    logic [W-2:0]         max_acc_reg, max_vel_reg;
    logic signed [W-1:0]  pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg;
    logic                 vpass_reg, alim_reg, vlim_reg;

    // Working vector and its limit.
    logic signed [W-1:0]  cx_reg, cy_reg;
    logic [W-2:0]         lim_reg;

    // Shared serial arithmetic.
    logic [W2-1:0]  acc_reg, sum_reg;
    logic [W-1:0]   ma_reg, mb_reg, root_reg, n_reg;
    logic [W+1:0]   rem_reg;

    // Output register.
    logic                 m_valid_reg;
    logic [4*W-1:0]       out_data_reg;
    logic [1:0]           out_user_reg;

    logic                 accept, load_out;
    logic [W-1:0]         mag_x, mag_y;
    logic [W:0]           mul_sum;
    logic [W+3:0]         sq_part;
    logic [W+3:0]         sq_trial;
    logic                 sq_ge;
    logic [W:0]           dv_part;
    logic                 dv_ge;
    logic                 dv_round;
    logic [W-1:0]         dv_q;
    logic signed [W-1:0]  dv_res;
    logic signed [W+2:0]  sx, sy, hx, hy;
    logic signed [W:0]    vsx, vsy;
    logic signed [W-1:0]  fin_px, fin_py, fin_vx, fin_vy;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign last_mul = (cnt_reg == CW'(W));
    assign last_div = (cnt_reg == CW'(W2 + 1));
    assign load_out = (state_reg == ST_OUT) && (!m_valid_reg || m_axis_tready);

    assign mag_x = cx_reg[W-1] ? W'(-cx_reg) : W'(cx_reg);
    assign mag_y = cy_reg[W-1] ? W'(-cy_reg) : W'(cy_reg);

    // Multiplier: one bit of mb per cycle, least significant first.
    assign mul_sum = {1'b0, acc_reg[W2-1:W]} + (mb_reg[0] ? {1'b0, ma_reg} : {(W+1){1'b0}});

    // Square root: one result bit per cycle, two radicand bits taken in.
    assign sq_part  = {rem_reg, sum_reg[W2-1:W2-2]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = (sq_part >= sq_trial);

    // Divider: one quotient bit per cycle, quotient shifts into acc from below.
    assign dv_part  = {rem_reg[W-1:0], acc_reg[W2-1]};
    assign dv_ge    = (dv_part >= {1'b0, n_reg});
    assign dv_round = ({rem_reg[W-1:0], 1'b0} >= {1'b0, n_reg});
    assign dv_q     = acc_reg[W-1:0] + W'(dv_round);

    always_comb
    begin
        dv_res = (state_reg == ST_DIVX) ? (cx_reg[W-1] ? -$signed(dv_q) : $signed(dv_q))
                                        : (cy_reg[W-1] ? -$signed(dv_q) : $signed(dv_q));
    end

    // Position update: 2p + 2v + a, halved with halves away from zero, saturated.
    always_comb
    begin
        sx = $signed({pos_x_reg[W-1], pos_x_reg, 1'b0}) + $signed({vel_x_reg[W-1], vel_x_reg, 1'b0})
             + (W+3)'(cx_reg);
        sy = $signed({pos_y_reg[W-1], pos_y_reg, 1'b0}) + $signed({vel_y_reg[W-1], vel_y_reg, 1'b0})
             + (W+3)'(cy_reg);
        hx = sx[W+2] ? (sx >>> 1) : ((sx + (W+3)'(1)) >>> 1);
        hy = sy[W+2] ? (sy >>> 1) : ((sy + (W+3)'(1)) >>> 1);
        fin_px = (hx > SMAX_E) ? SMAX_E[W-1:0] : ((hx < SMIN_E) ? SMIN_E[W-1:0] : hx[W-1:0]);
        fin_py = (hy > SMAX_E) ? SMAX_E[W-1:0] : ((hy < SMIN_E) ? SMIN_E[W-1:0] : hy[W-1:0]);
        vsx = (W+1)'(vel_x_reg) + (W+1)'(cx_reg);
        vsy = (W+1)'(vel_y_reg) + (W+1)'(cy_reg);
        fin_vx = (vsx[W] != vsx[W-1]) ? {vsx[W], {(W-1){~vsx[W]}}} : vsx[W-1:0];
        fin_vy = (vsy[W] != vsy[W-1]) ? {vsy[W], {(W-1){~vsy[W]}}} : vsy[W-1:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (s_axis_tuser == OP_STEP) ? ST_SQX : ST_OUT;
                end
            end
            ST_SQX:  if (last_mul) state_next = ST_SQY;
            ST_SQY:  if (last_mul) state_next = ST_SQL;
            ST_SQL:  if (last_mul) state_next = ST_CMP;
            ST_CMP:  state_next = (sum_reg > acc_reg) ? ST_ROOT : ST_FIN;
            ST_ROOT: if (last_mul) state_next = ST_MULX;
            ST_MULX: if (last_mul) state_next = ST_DIVX;
            ST_DIVX: if (last_div) state_next = ST_MULY;
            ST_MULY: if (last_mul) state_next = ST_DIVY;
            ST_DIVY: if (last_div) state_next = ST_FIN;
            ST_FIN:  state_next = vpass_reg ? ST_OUT : ST_SQX;
            ST_OUT:  if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        cfg_ready     = 1'b1;
        m_axis_tvalid = m_valid_reg;
        m_axis_tdata  = TD_W'(out_data_reg);
        m_axis_tuser  = out_user_reg;
    end

    // Control state, architectural state and limits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            max_acc_reg <= LIM_ONE;
            max_vel_reg <= LIM_ONE;
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            vel_x_reg   <= '0;
            vel_y_reg   <= '0;
            vpass_reg   <= 1'b0;
            alim_reg    <= 1'b0;
            vlim_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= (state_next != state_reg) ? '0 : cnt_reg + CW'(1);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_MAX_ACCEL)
                begin
                    max_acc_reg <= cfg_data;
                end
                else
                begin
                    max_vel_reg <= cfg_data;
                end
            end
            if (accept)
            begin
                alim_reg  <= 1'b0;
                vlim_reg  <= 1'b0;
                vpass_reg <= 1'b0;
                if (s_axis_tuser == OP_INIT)
                begin
                    pos_x_reg <= s_axis_tdata[3*W-1:2*W];
                    pos_y_reg <= s_axis_tdata[4*W-1:3*W];
                    vel_x_reg <= '0;
                    vel_y_reg <= '0;
                end
            end
            if ((state_reg == ST_CMP) && (sum_reg > acc_reg))
            begin
                if (vpass_reg)
                begin
                    vlim_reg <= 1'b1;
                end
                else
                begin
                    alim_reg <= 1'b1;
                end
            end
            if (state_reg == ST_FIN)
            begin
                if (vpass_reg)
                begin
                    vel_x_reg <= cx_reg;
                    vel_y_reg <= cy_reg;
                end
                else
                begin
                    pos_x_reg <= fin_px;
                    pos_y_reg <= fin_py;
                    vpass_reg <= 1'b1;
                end
            end
            if (load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Serial datapath and output payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cx_reg  <= s_axis_tdata[W-1:0];
            cy_reg  <= s_axis_tdata[2*W-1:W];
            lim_reg <= max_acc_reg;
        end
        if (load_out)
        begin
            out_data_reg <= {vel_y_reg, vel_x_reg, pos_y_reg, pos_x_reg};
            out_user_reg <= {vlim_reg, alim_reg};
        end
        case (state_reg)
            ST_SQX, ST_SQY, ST_SQL, ST_MULX, ST_MULY:
            begin
                if (cnt_reg == '0)
                begin
                    acc_reg <= '0;
                    case (state_reg)
                        ST_SQX:
                        begin
                            ma_reg <= mag_x;
                            mb_reg <= mag_x;
                        end
                        ST_SQY:
                        begin
                            ma_reg <= mag_y;
                            mb_reg <= mag_y;
                        end
                        ST_SQL:
                        begin
                            ma_reg <= {1'b0, lim_reg};
                            mb_reg <= {1'b0, lim_reg};
                        end
                        ST_MULX:
                        begin
                            ma_reg <= {1'b0, lim_reg};
                            mb_reg <= mag_x;
                            n_reg  <= (root_reg == '0) ? W'(1) : root_reg;
                        end
                        default:
                        begin
                            ma_reg <= {1'b0, lim_reg};
                            mb_reg <= mag_y;
                        end
                    endcase
                end
                else
                begin
                    acc_reg <= {mul_sum, acc_reg[W-1:1]};
                    mb_reg  <= mb_reg >> 1;
                    if (last_mul && (state_reg == ST_SQX))
                    begin
                        sum_reg <= {mul_sum, acc_reg[W-1:1]};
                    end
                    if (last_mul && (state_reg == ST_SQY))
                    begin
                        sum_reg <= sum_reg + {mul_sum, acc_reg[W-1:1]};
                    end
                end
            end
            ST_ROOT:
            begin
                if (cnt_reg == '0)
                begin
                    rem_reg  <= '0;
                    root_reg <= '0;
                end
                else
                begin
                    rem_reg  <= sq_ge ? (W+2)'(sq_part - sq_trial) : sq_part[W+1:0];
                    root_reg <= {root_reg[W-2:0], sq_ge};
                    sum_reg  <= {sum_reg[W2-3:0], 2'b00};
                end
            end
            ST_DIVX, ST_DIVY:
            begin
                if (cnt_reg == '0)
                begin
                    rem_reg <= '0;
                end
                else if (!last_div)
                begin
                    rem_reg <= {2'b00, dv_ge ? W'(dv_part - {1'b0, n_reg}) : dv_part[W-1:0]};
                    acc_reg <= {acc_reg[W2-2:0], dv_ge};
                end
                else if (state_reg == ST_DIVX)
                begin
                    cx_reg <= dv_res;
                end
                else
                begin
                    cy_reg <= dv_res;
                end
            end
            ST_FIN:
            begin
                if (!vpass_reg)
                begin
                    cx_reg  <= fin_vx;
                    cy_reg  <= fin_vy;
                    lim_reg <= max_vel_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    `ASSERT_CLK(a_out_held, (state_reg == ST_OUT) && m_valid_reg && !m_axis_tready |=> (state_reg == ST_OUT), "result overwritten while still waiting")
    `ASSERT_CLK(a_init_fast, accept && (s_axis_tuser == OP_INIT) |=> (state_reg == ST_OUT), "initialize beat did not go straight to output")
    `ASSERT_CLK(a_div_nonzero, (state_reg == ST_DIVX) || (state_reg == ST_DIVY) |-> (n_reg != '0), "divider started with a zero norm")
    `ASSERT_ALWAYS(a_ready_idle, s_axis_tready |-> (state_reg == ST_IDLE), "input taken while busy")

endmodule

`default_nettype wire

// File: tb/sv/tb_double_integrator_clamped_step.sv
// Self-checking testbench for the clamped double integrator block.
// Depends on dicl_pkg and the RTL top level double_integrator_clamped_step.
`timescale 1ns / 100ps

module tb_double_integrator_clamped_step;
    import dicl_pkg::*;

    localparam int W = DEF_WORD_BITS;
    localparam int DW = ((4*W+7)/8)*8;
    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;
    localparam int LIMIT_CYCLES = 4000000;
    localparam int HOLD_CYCLES = 3000;

    // One input beat of the directed table; chk marks rows whose result is typed in.
    typedef struct {
        logic op;
        logic [W-1:0] gx, gy, sx, sy;
        bit chk;
        logic [W-1:0] px, py, vx, vy;
        logic al, sl;
    } row_t;

    typedef struct {
        logic [W-1:0] px, py, vx, vy;
        logic al, sl;
    } motion_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [DW-1:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [DW-1:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = CFG_MAX_ACCEL;
    logic [W-2:0] cfg_data = '0;

    double_integrator_clamped_step u_top (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state: the agent's position, velocity and both norm limits.
    longint agent_px, agent_py, agent_vx, agent_vy;
    longint unsigned lim_accel, lim_vel;

    motion_t expected_motion[$];
    int errors = 0;
    bit hold_off = 0;
    longint cycle_count = 0;

    function automatic longint clip(input logic signed [127:0] x);
        if (x > SMAX)
            return SMAX;
        if (x < SMIN)
            return SMIN;
        return longint'(x);
    endfunction

    // Integer square root, floor, of a value below 2^128.
    function automatic logic [127:0] isqrt(input logic [127:0] x);
        logic [127:0] r, t;
        r = 0;
        for (int i = 63; i >= 0; i--)
        begin
            t = r | (128'd1 << i);
            if (t * t <= x)
                r = t;
        end
        return r;
    endfunction

    // Rescale (x, y) to length lim when its norm exceeds lim; returns whether it did.
    function automatic bit clamp_to_norm(input longint unsigned lim,
                                         inout longint x, inout longint y);
        logic [127:0] mx, my, sumsq, n, q, l;
        mx = (x < 0) ? -x : x;
        my = (y < 0) ? -y : y;
        l = lim;
        sumsq = mx*mx + my*my;
        if (sumsq <= l*l)
            return 0;
        n = isqrt(sumsq);
        if (n == 0)
            n = 1;
        // Halves round away from zero on the magnitude.
        q = (2*l*mx + n) / (2*n);
        if (q > 128'h8000_0000)
            q = 128'h8000_0000;
        x = clip((x < 0) ? -$signed(q) : $signed(q));
        q = (2*l*my + n) / (2*n);
        if (q > 128'h8000_0000)
            q = 128'h8000_0000;
        y = clip((y < 0) ? -$signed(q) : $signed(q));
        return 1;
    endfunction

    function automatic longint halve_round(input longint s);
        if (s >= 0)
            return (s + 1) / 2;
        return -((-s + 1) / 2);
    endfunction

    function automatic motion_t advance_agent(input logic op, input logic [W-1:0] gx,
        input logic [W-1:0] gy, input logic [W-1:0] sx, input logic [W-1:0] sy);
        motion_t m;
        longint ax, ay, nvx, nvy;
        m.al = 0;
        m.sl = 0;
        if (op == OP_INIT)
        begin
            agent_px = longint'($signed(sx));
            agent_py = longint'($signed(sy));
            agent_vx = 0;
            agent_vy = 0;
        end
        else
        begin
            ax = longint'($signed(gx));
            ay = longint'($signed(gy));
            m.al = clamp_to_norm(lim_accel, ax, ay);
            agent_px = clip(halve_round(2*agent_px + 2*agent_vx + ax));
            agent_py = clip(halve_round(2*agent_py + 2*agent_vy + ay));
            nvx = clip(agent_vx + ax);
            nvy = clip(agent_vy + ay);
            m.sl = clamp_to_norm(lim_vel, nvx, nvy);
            agent_vx = nvx;
            agent_vy = nvy;
        end
        m.px = agent_px[W-1:0];
        m.py = agent_py[W-1:0];
        m.vx = agent_vx[W-1:0];
        m.vy = agent_vy[W-1:0];
        return m;
    endfunction

    task automatic write_limit(input logic idx, input logic [W-2:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_MAX_ACCEL)
            lim_accel = val;
        else
            lim_vel = val;
    endtask

    // Offers one beat and waits for its acceptance; valid stays high across beats.
    task automatic send_beat(input logic op, input logic [W-1:0] gx, input logic [W-1:0] gy,
        input logic [W-1:0] sx, input logic [W-1:0] sy, input bit chk, input motion_t typed);
        motion_t m;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {sy, sx, gy, gx};
        do @(posedge clk); while (!s_axis_tready);
        m = advance_agent(op, gx, gy, sx, sy);
        if (chk && m != typed)
        begin
            $error("directed row disagrees with predictor");
            errors++;
        end
        expected_motion.insert(expected_motion.size(), chk ? typed : m);
    endtask

    task automatic pause_sender();
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drops valid, waits for all results, then idles on before reconfiguring.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_motion.size() != 0)
            @(posedge clk);
        repeat (20*W + 40) @(posedge clk);
    endtask

    function automatic logic [W-1:0] rand_word(input int kind);
        case (kind)
            0: return $urandom;
            1: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
            2: return $urandom_range(0, 32'h300) - 32'h180;
            default: return ($urandom_range(0, 1)) ? 32'h7fff_ffff : 32'h8000_0000;
        endcase
    endfunction

    // Result checking against the oldest expectation.
    always @(posedge clk)
    begin
        motion_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_motion.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                errors++;
            end
            else
            begin
                e = expected_motion.pop_front();
                if (m_axis_tdata[W-1:0] !== e.px)
                begin
                    $error("pos_x expected %h actual %h", e.px, m_axis_tdata[W-1:0]);
                    errors++;
                end
                if (m_axis_tdata[2*W-1:W] !== e.py)
                begin
                    $error("pos_y expected %h actual %h", e.py, m_axis_tdata[2*W-1:W]);
                    errors++;
                end
                if (m_axis_tdata[3*W-1:2*W] !== e.vx)
                begin
                    $error("vel_x expected %h actual %h", e.vx, m_axis_tdata[3*W-1:2*W]);
                    errors++;
                end
                if (m_axis_tdata[4*W-1:3*W] !== e.vy)
                begin
                    $error("vel_y expected %h actual %h", e.vy, m_axis_tdata[4*W-1:3*W]);
                    errors++;
                end
                if (m_axis_tuser[0] !== e.al)
                begin
                    $error("accel_limited expected %b actual %b", e.al, m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tuser[1] !== e.sl)
                begin
                    $error("speed_limited expected %b actual %b", e.sl, m_axis_tuser[1]);
                    errors++;
                end
            end
        end
    end

    // Receiver: stalls on a pattern of its own, with one long hold-off on request.
    always @(posedge clk)
    begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= (cycle_count[9:8] == 2'b11) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        row_t rows[$];
        motion_t typed;
        logic [W-2:0] lims[4];
        int op_kind;
        lim_accel = 64'h1_0000;
        lim_vel = 64'h1_0000;
        agent_px = 0; agent_py = 0; agent_vx = 0; agent_vy = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Results are typed only where obvious.
        rows.insert(rows.size(), '{OP_STEP, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0});
        rows.insert(rows.size(), '{OP_INIT, 5, 5, 32'h7fff_ffff, 32'h8000_0000, 1,
                                   32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0});
        rows.insert(rows.size(), '{OP_STEP, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0,
                                   0, 0, 0, 0, 0, 0});
        rows.insert(rows.size(), '{OP_STEP, 32'h8000_0000, 32'h8000_0000, 0, 0, 0,
                                   0, 0, 0, 0, 0, 0});
        rows.insert(rows.size(), '{OP_INIT, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0});
        rows.insert(rows.size(), '{OP_STEP, 32'h0_8000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        rows.insert(rows.size(), '{OP_STEP, 32'h0_0001, 32'hffff_ffff, 0, 0, 0,
                                   0, 0, 0, 0, 0, 0});
        rows.insert(rows.size(), '{OP_STEP, 32'h1_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        rows.insert(rows.size(), '{OP_STEP, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0,
                                   0, 0, 0, 0, 0, 0});
        rows.insert(rows.size(), '{OP_INIT, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 0,
                                   0, 0, 0, 0, 0, 0});
        rows.insert(rows.size(), '{OP_STEP, 32'hffff_0000, 32'h0001_0000, 0, 0, 0,
                                   0, 0, 0, 0, 0, 0});
        foreach (rows[i])
        begin
            typed = '{rows[i].px, rows[i].py, rows[i].vx, rows[i].vy, rows[i].al, rows[i].sl};
            send_beat(rows[i].op, rows[i].gx, rows[i].gy, rows[i].sx, rows[i].sy,
                      rows[i].chk, typed);
        end
        drain();

        // Zero limits: any nonzero command and velocity are forced to zero.
        write_limit(CFG_MAX_ACCEL, '0);
        write_limit(CFG_MAX_VEL, '0);
        typed = '{32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0};
        send_beat(OP_INIT, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 1, typed);
        typed = '{32'h7fff_ffff, 32'h8000_0000, 0, 0, 1, 0};
        send_beat(OP_STEP, 32'h0001_0000, 32'h0, 0, 0, 1, typed);
        drain();

        lims[0] = '1;
        lims[1] = 31'h0002_0000;
        lims[2] = 31'h0000_0100;
        lims[3] = 31'h4000_0000;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_limit(CFG_MAX_ACCEL, (ph == 5) ? 31'h0 : lims[$urandom_range(0, 3)]);
            write_limit(CFG_MAX_VEL, (ph == 0) ? '1 : lims[$urandom_range(0, 3)]);
            for (int k = 0; k < 215; k++)
            begin
                // Mostly steps from the current state; a sixth are re-initialisations.
                op_kind = $urandom_range(0, 5);
                // The long hold-off runs in its own process.
                if (ph == 2 && k == 20)
                begin
                    fork
                        begin
                            hold_off = 1;
                            repeat (HOLD_CYCLES) @(posedge clk);
                            hold_off = 0;
                        end
                    join_none
                end
                send_beat((op_kind == 0) ? OP_INIT : OP_STEP,
                          rand_word($urandom_range(0, 3)), rand_word($urandom_range(0, 3)),
                          rand_word($urandom_range(0, 3)), rand_word($urandom_range(0, 3)),
                          0, typed);
                pause_sender();
            end
            drain();
        end

        if (errors == 0 && expected_motion.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
